// File: rtl/hd_pkg.sv
// Package for the haversine distance pipeline.
// Holds fixed-point constants, the CORDIC angle table and the CORDIC step functions.
// Used by haversine_distance; depends on nothing.
`default_nettype none

package hd_pkg;

    // Q30 fixed-point constants.
    localparam logic [33:0] Q30_ONE  = 34'd1073741824;
    localparam logic [33:0] Q31_TWO  = 34'd2147483648;
    localparam logic [33:0] GAIN_INV = 34'd652032874;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [29:0] HALF_Q30 = 30'd536870912;

    // Widths that follow from the Q30 formats.
    localparam int unsigned CW = 34;
    localparam int unsigned SQ_STEPS = 32;

    // One CORDIC vector with its residual angle.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    // Arctangent of 2^-i in binary angle units.
    function automatic logic signed [CW-1:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0: v = 32'h20000000;
                5'd1: v = 32'h12E4051E;
                5'd2: v = 32'h09FB385B;
                5'd3: v = 32'h051111D4;
                5'd4: v = 32'h028B0D43;
                5'd5: v = 32'h0145D7E1;
                5'd6: v = 32'h00A2F61E;
                5'd7: v = 32'h00517C55;
                5'd8: v = 32'h0028BE53;
                5'd9: v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_bam = $signed({2'b00, v});
        end
    endfunction

    // One rotation step: drives the residual angle toward zero.
    function automatic cordic_t rot_step(input cordic_t c, input logic [4:0] i);
        cordic_t r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        begin
            dx = c.y >>> i;
            dy = c.x >>> i;
            if (c.z >= 0)
            begin
                r.x = c.x - dx;
                r.y = c.y + dy;
                r.z = c.z - atan_bam(i);
            end
            else
            begin
                r.x = c.x + dx;
                r.y = c.y - dy;
                r.z = c.z + atan_bam(i);
            end
            rot_step = r;
        end
    endfunction

    // One vectoring step: drives y toward zero and sums the angle.
    function automatic cordic_t vec_step(input cordic_t c, input logic [4:0] i);
        cordic_t r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        begin
            dx = c.y >>> i;
            dy = c.x >>> i;
            if (c.y >= 0)
            begin
                r.x = c.x + dx;
                r.y = c.y - dy;
                r.z = c.z + atan_bam(i);
            end
            else
            begin
                r.x = c.x - dx;
                r.y = c.y + dy;
                r.z = c.z - atan_bam(i);
            end
            vec_step = r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/hd_if.sv
// Stream interfaces for the haversine distance block.
// Carry valid, ready and the point-pair or distance word; no dependencies.
`default_nettype none

interface hd_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [31:0] lat_b;
    logic signed [31:0] lon_b;
    modport source (output valid, output lat_a, output lon_a, output lat_b,
                    output lon_b, input ready);
    modport sink (input valid, input lat_a, input lon_a, input lat_b,
                  input lon_b, output ready);
endinterface

interface hd_dist_if;
    logic        valid;
    logic        ready;
    logic [25:0] distance_m;
    modport source (output valid, output distance_m, input ready);
    modport sink (input valid, input distance_m, output ready);
endinterface

`default_nettype wire

// File: rtl/haversine_distance.sv
// Haversine great-circle distance, fully pipelined.
// Depends on hd_pkg and the stream interfaces in hd_if.sv.
//
//   channel   dir   word                               handshake
//   points    in    lat_a, lon_a, lat_b, lon_b (s32)   valid/ready
//   result    out   distance_m (u26)                   valid/ready
//   cfg       in    earth_radius_m (u24)               cfg_we
//
// One word enters per cycle while the result is not stalled; the pipeline depth is set by
// the two CORDIC chains and the 32-step square-root chain.
// Reset empties the pipeline and loads the radius 6378100.
// A stalled result freezes every stage; nothing is dropped or repeated.
`default_nettype none

module haversine_distance #(
    parameter int unsigned CORDIC_STEPS = 24
) (
    input  wire         clk,
    input  wire         rst_n,
    hd_point_if.sink    points,
    hd_dist_if.source   result,
    input  wire         cfg_we,
    input  wire  [23:0] cfg_wdata
);

    localparam int unsigned N = CORDIC_STEPS;
    localparam int unsigned CW = hd_pkg::CW;
    localparam int unsigned SQ = hd_pkg::SQ_STEPS;
    // Stage positions in the valid chain.
    localparam int unsigned P_PROD = N + 1;
    localparam int unsigned P_TERM = N + 2;
    localparam int unsigned P_SQ0  = N + 3;
    localparam int unsigned P_VEC0 = P_SQ0 + SQ + 1;
    localparam int unsigned P_RAD  = P_VEC0 + N + 1;
    localparam int unsigned P_DIST = P_RAD + 1;
    localparam int unsigned L = P_DIST + 1;

    logic adv;
    logic [L-1:0] vld_reg;
    logic [23:0] radius_reg;

    // The whole pipeline moves unless the output word is stalled.
    assign adv = !vld_reg[L-1] || result.ready;
    assign points.ready = adv;

    // Radius register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= 24'd6378100;
        else if (cfg_we)
            radius_reg <= cfg_wdata;
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[L-2:0], points.valid};
    end

    // ---------------- Sine/cosine engines ----------------
    // Engine 0: half latitude difference, 1: half longitude difference,
    // 2: latitude a, 3: latitude b.
    hd_pkg::cordic_t sc_reg [0:N][0:3];
    logic [3:0] flip_reg [0:N];

    logic [31:0] dlat;
    logic [31:0] dlon;
    logic [31:0] mlat;
    logic [31:0] mlon;
    logic signed [CW-1:0] za;
    logic signed [CW-1:0] zb;

    // Half of the wrapped difference magnitude, at most a quarter turn.
    always_comb
    begin
        dlat = points.lat_a - points.lat_b;
        dlon = points.lon_a - points.lon_b;
        mlat = dlat[31] ? (~dlat + 32'd1) : dlat;
        mlon = dlon[31] ? (~dlon + 32'd1) : dlon;
        za = CW'(points.lat_a);
        zb = CW'(points.lat_b);
    end

    // Fold an angle into the right half plane; remembers the sign flip.
    function automatic logic [CW:0] fold(input logic signed [CW-1:0] z);
        logic signed [CW-1:0] r;
        logic f;
        begin
            r = z;
            f = 1'b0;
            if (z > $signed(hd_pkg::Q30_ONE))
            begin
                r = z - $signed(hd_pkg::Q31_TWO);
                f = 1'b1;
            end
            else if (z < -$signed(hd_pkg::Q30_ONE))
            begin
                r = z + $signed(hd_pkg::Q31_TWO);
                f = 1'b1;
            end
            fold = {f, r};
        end
    endfunction

    logic [CW:0] fa;
    logic [CW:0] fb;
    assign fa = fold(za);
    assign fb = fold(zb);

    // Entry stage: load the four start vectors.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_reg[0][0] <= '{x: $signed(hd_pkg::GAIN_INV), y: '0,
                              z: $signed(CW'({1'b0, mlat[31:1]}))};
            sc_reg[0][1] <= '{x: $signed(hd_pkg::GAIN_INV), y: '0,
                              z: $signed(CW'({1'b0, mlon[31:1]}))};
            sc_reg[0][2] <= '{x: $signed(hd_pkg::GAIN_INV), y: '0,
                              z: $signed(fa[CW-1:0])};
            sc_reg[0][3] <= '{x: $signed(hd_pkg::GAIN_INV), y: '0,
                              z: $signed(fb[CW-1:0])};
            flip_reg[0] <= {fb[CW], fa[CW], 2'b00};
        end
    end

    // Rotation stages, one step per stage.
    genvar k;
    genvar e;
    generate
        for (k = 0; k < N; k++)
        begin : g_rot
            for (e = 0; e < 4; e++)
            begin : g_eng
                always_ff @(posedge clk)
                begin
                    if (adv)
                        sc_reg[k+1][e] <= hd_pkg::rot_step(sc_reg[k][e], 5'(k));
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    flip_reg[k+1] <= flip_reg[k];
            end
        end
    endgenerate

    // ---------------- Products ----------------
    logic [CW-1:0] m_slat;
    logic [CW-1:0] m_slon;
    logic [CW-1:0] m_ca;
    logic [CW-1:0] m_cb;
    logic neg_c;
    logic [67:0] p_slat;
    logic [67:0] p_slon;
    logic [67:0] p_cc;

    // Magnitudes; the folded sign is carried only in the cosine sign.
    always_comb
    begin
        m_slat = sc_reg[N][0].y[CW-1] ? CW'(-sc_reg[N][0].y) : sc_reg[N][0].y;
        m_slon = sc_reg[N][1].y[CW-1] ? CW'(-sc_reg[N][1].y) : sc_reg[N][1].y;
        m_ca = sc_reg[N][2].x[CW-1] ? CW'(-sc_reg[N][2].x) : sc_reg[N][2].x;
        m_cb = sc_reg[N][3].x[CW-1] ? CW'(-sc_reg[N][3].x) : sc_reg[N][3].x;
        neg_c = (sc_reg[N][2].x[CW-1] ^ flip_reg[N][2]) ^
                (sc_reg[N][3].x[CW-1] ^ flip_reg[N][3]);
        // A zero cosine is never negative after the flip.
        if (sc_reg[N][2].x == '0 || sc_reg[N][3].x == '0)
            neg_c = 1'b0;
        p_slat = m_slat * m_slat;
        p_slon = m_slon * m_slon;
        p_cc = m_ca * m_cb;
    end

    logic [33:0] slat_reg;
    logic [33:0] slon_reg;
    logic [33:0] pm_reg;
    logic neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slat_reg <= p_slat[63:30];
            slon_reg <= p_slon[63:30];
            pm_reg <= p_cc[63:30];
            neg_reg <= neg_c;
        end
    end

    // ---------------- Cross term ----------------
    logic [33:0] pm_clamp;
    logic [67:0] p_term;
    assign pm_clamp = (pm_reg > hd_pkg::Q31_TWO) ? hd_pkg::Q31_TWO : pm_reg;
    assign p_term = pm_clamp * slon_reg;

    logic [33:0] slat2_reg;
    logic [37:0] term_reg;
    logic neg2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slat2_reg <= slat_reg;
            term_reg <= p_term[67:30];
            neg2_reg <= neg_reg;
        end
    end

    // ---------------- Sum, clamp and square roots ----------------
    logic signed [39:0] a_sum;
    logic [30:0] a_next;
    always_comb
    begin
        a_sum = neg2_reg ? ($signed({6'b0, slat2_reg}) - $signed({2'b0, term_reg}))
                         : ($signed({6'b0, slat2_reg}) + $signed({2'b0, term_reg}));
        if (a_sum < 0)
            a_next = '0;
        else if (a_sum > $signed(40'(hd_pkg::Q30_ONE)))
            a_next = 31'(hd_pkg::Q30_ONE);
        else
            a_next = a_sum[30:0];
    end

    // Engine 0: sqrt(a), engine 1: sqrt(1 - a).
    logic [63:0] sv_reg [0:SQ][0:1];
    logic [63:0] sr_reg [0:SQ][0:1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sv_reg[0][0] <= {3'b0, a_next, 30'b0};
            sv_reg[0][1] <= {3'b0, 31'(hd_pkg::Q30_ONE) - a_next, 30'b0};
            sr_reg[0][0] <= '0;
            sr_reg[0][1] <= '0;
        end
    end

    // Restoring square root, one result bit per stage.
    generate
        for (k = 0; k < SQ; k++)
        begin : g_sq
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            for (e = 0; e < 2; e++)
            begin : g_eng
                logic [63:0] trial;
                assign trial = sr_reg[k][e] + BIT;
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        if (sv_reg[k][e] >= trial)
                        begin
                            sv_reg[k+1][e] <= sv_reg[k][e] - trial;
                            sr_reg[k+1][e] <= (sr_reg[k][e] >> 1) + BIT;
                        end
                        else
                        begin
                            sv_reg[k+1][e] <= sv_reg[k][e];
                            sr_reg[k+1][e] <= sr_reg[k][e] >> 1;
                        end
                    end
                end
            end
        end
    endgenerate

    // ---------------- Vectoring CORDIC ----------------
    hd_pkg::cordic_t vc_reg [0:N];

    always_ff @(posedge clk)
    begin
        if (adv)
            vc_reg[0] <= '{x: $signed(CW'(sr_reg[SQ][1][31:0])),
                           y: $signed(CW'(sr_reg[SQ][0][31:0])), z: '0};
    end

    generate
        for (k = 0; k < N; k++)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (adv)
                    vc_reg[k+1] <= hd_pkg::vec_step(vc_reg[k], 5'(k));
            end
        end
    endgenerate

    // ---------------- Scaling to metres ----------------
    logic [30:0] z_clamp;
    logic [62:0] p_rad;
    always_comb
    begin
        if (vc_reg[N].z < 0)
            z_clamp = '0;
        else if (vc_reg[N].z > $signed(hd_pkg::Q30_ONE))
            z_clamp = 31'(hd_pkg::Q30_ONE);
        else
            z_clamp = vc_reg[N].z[30:0];
        p_rad = z_clamp * hd_pkg::PI_Q30 + 63'(hd_pkg::HALF_Q30);
    end

    logic [31:0] rad_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            rad_reg <= p_rad[61:30];
    end

    logic [55:0] p_dist;
    assign p_dist = radius_reg * rad_reg + 56'(hd_pkg::HALF_Q30);

    logic [25:0] dist_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            dist_reg <= p_dist[55:30];
    end

    assign result.valid = vld_reg[L-1];
    assign result.distance_m = dist_reg;

    // ---------------- Assertions ----------------
    // The clamped sum handed to the square roots never exceeds one.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_SQ0] |-> (sv_reg[0][0][62:30] <= 33'(hd_pkg::Q30_ONE)))
        else $error("square-root argument above one");

    // The central angle in radians never exceeds pi.
    a_rad: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_RAD] |-> (rad_reg <= hd_pkg::PI_Q30))
        else $error("central angle above pi");

    // Neither square-root result handed to the vectoring CORDIC exceeds one.
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_VEC0] |-> (vc_reg[0].x <= $signed(hd_pkg::Q30_ONE)
                             && vc_reg[0].y <= $signed(hd_pkg::Q30_ONE)))
        else $error("square root above one");

    // A held output word leaves the valid chain and the radian register frozen.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[L-1] && !result.ready) |=> $stable(vld_reg) && $stable(rad_reg))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
